// ===== rtl/smd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smd_pkg
// Shared types and constants for the serial message deframer.
// ----------------------------------------------------------------------------
package smd_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'h45;
  localparam logic [7:0] SYNC_SECOND = 8'h52;
  localparam logic [7:0] BYTE_ONES   = 8'hFF;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_BODY      = 2'd0;
  localparam kind_t KIND_FRAME_OK  = 2'd1;
  localparam kind_t KIND_BODY_ERR  = 2'd2;
  localparam kind_t KIND_HDR_ERR   = 2'd3;

  // one result produced by the parser for the byte presented this cycle
  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] src_addr;
    logic [7:0] reg_num;
    logic [7:0] flag_bits;
    logic [7:0] body_length;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
  } smd_result_t;

endpackage

// ===== rtl/smd_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smd_in_if
// Received byte channel: valid/ready handshake with one byte of payload.
// ----------------------------------------------------------------------------
interface smd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/smd_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smd_out_if
// Deframer result channel: valid/ready handshake with the frame result fields.
// ----------------------------------------------------------------------------
interface smd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] src_addr;
  logic [7:0] reg_num;
  logic [7:0] flag_bits;
  logic [7:0] body_length;
  logic [7:0] data_byte;
  logic [7:0] byte_index;

  modport source (output valid, output kind, output src_addr, output reg_num,
                  output flag_bits, output body_length, output data_byte,
                  output byte_index, input ready);
  modport sink   (input valid, input kind, input src_addr, input reg_num,
                  input flag_bits, input body_length, input data_byte,
                  input byte_index, output ready);
endinterface

// ===== rtl/smd_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smd_parser
// Frame state machine: tracks the frame phase, header fields and checksums,
// and computes the result caused by the byte taken this cycle.
// ----------------------------------------------------------------------------
module smd_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_fire,
  input  logic [7:0]          rx_byte,
  input  logic [7:0]          node_id,
  output smd_pkg::smd_result_t res
);
  import smd_pkg::*;

  localparam logic [3:0] PH_HUNT  = 4'd0;
  localparam logic [3:0] PH_SYNC2 = 4'd1;
  localparam logic [3:0] PH_SRC   = 4'd2;
  localparam logic [3:0] PH_DST   = 4'd3;
  localparam logic [3:0] PH_REG   = 4'd4;
  localparam logic [3:0] PH_FLAGS = 4'd5;
  localparam logic [3:0] PH_LEN   = 4'd6;
  localparam logic [3:0] PH_HCHK  = 4'd7;
  localparam logic [3:0] PH_BODY  = 4'd8;
  localparam logic [3:0] PH_BCHK  = 4'd9;

  logic [3:0] phase_r,      phase_nxt;
  logic [7:0] source_r,     source_nxt;
  logic [7:0] register_r,   register_nxt;
  logic [7:0] flags_r,      flags_nxt;
  logic [7:0] length_r,     length_nxt;
  logic [7:0] hdr_sum_r,    hdr_sum_nxt;
  logic [7:0] body_sum_r,   body_sum_nxt;
  logic [7:0] body_count_r, body_count_nxt;
  logic [7:0] count_inc;

  assign count_inc = body_count_r + 8'd1;

  always_comb begin
    phase_nxt      = phase_r;
    source_nxt     = source_r;
    register_nxt   = register_r;
    flags_nxt      = flags_r;
    length_nxt     = length_r;
    hdr_sum_nxt    = hdr_sum_r;
    body_sum_nxt   = body_sum_r;
    body_count_nxt = body_count_r;

    res.valid       = 1'b0;
    res.kind        = KIND_BODY;
    res.src_addr    = source_r;
    res.reg_num     = register_r;
    res.flag_bits   = flags_r;
    res.body_length = length_r;
    res.data_byte   = 8'd0;
    res.byte_index  = 8'd0;

    case (phase_r)
      PH_SYNC2: begin
        if (rx_byte == SYNC_SECOND) begin
          phase_nxt = PH_SRC;
        end else if (rx_byte == SYNC_FIRST) begin
          phase_nxt = PH_SYNC2;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_SRC: begin
        source_nxt  = rx_byte;
        hdr_sum_nxt = rx_byte;
        phase_nxt   = PH_DST;
      end
      PH_DST: begin
        // frame for another node is dropped without a result
        if (rx_byte != node_id) begin
          phase_nxt = PH_HUNT;
        end else begin
          hdr_sum_nxt = hdr_sum_r + rx_byte;
          phase_nxt   = PH_REG;
        end
      end
      PH_REG: begin
        register_nxt = rx_byte;
        hdr_sum_nxt  = hdr_sum_r + rx_byte;
        phase_nxt    = PH_FLAGS;
      end
      PH_FLAGS: begin
        flags_nxt   = rx_byte;
        hdr_sum_nxt = hdr_sum_r + rx_byte;
        phase_nxt   = PH_LEN;
      end
      PH_LEN: begin
        length_nxt  = rx_byte;
        hdr_sum_nxt = hdr_sum_r + rx_byte;
        phase_nxt   = PH_HCHK;
      end
      PH_HCHK: begin
        if (rx_byte != (hdr_sum_r ^ BYTE_ONES)) begin
          phase_nxt = PH_HUNT;
          res.valid = 1'b1;
          res.kind  = KIND_HDR_ERR;
        end else begin
          body_sum_nxt   = 8'd0;
          body_count_nxt = 8'd0;
          // empty body closes the frame without a body check byte
          if (length_r == 8'd0) begin
            phase_nxt = PH_HUNT;
            res.valid = 1'b1;
            res.kind  = KIND_FRAME_OK;
          end else begin
            phase_nxt = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        res.valid      = 1'b1;
        res.kind       = KIND_BODY;
        res.data_byte  = rx_byte;
        res.byte_index = body_count_r;
        body_sum_nxt   = body_sum_r + rx_byte;
        body_count_nxt = count_inc;
        if (count_inc == length_r) begin
          phase_nxt = PH_BCHK;
        end
      end
      PH_BCHK: begin
        phase_nxt = PH_HUNT;
        res.valid = 1'b1;
        res.kind  = (rx_byte == (body_sum_r ^ BYTE_ONES)) ? KIND_FRAME_OK : KIND_BODY_ERR;
      end
      default: begin
        phase_nxt = (rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
    end else if (byte_fire) begin
      phase_r <= phase_nxt;
    end
  end

  // header and sum registers are always written before a frame reads them
  always_ff @(posedge clk) begin
    if (byte_fire) begin
      source_r     <= source_nxt;
      register_r   <= register_nxt;
      flags_r      <= flags_nxt;
      length_r     <= length_nxt;
      hdr_sum_r    <= hdr_sum_nxt;
      body_sum_r   <= body_sum_nxt;
      body_count_r <= body_count_nxt;
    end
  end

  a_body_count_below_length: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BODY) |-> (body_count_r < length_r))
    else $error("body count reached declared length while still in body");

  a_body_check_after_full_body: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BCHK) |-> (body_count_r == length_r && length_r != 8'd0))
    else $error("body check phase entered with incomplete body");

  a_result_only_late_phases: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> (phase_r == PH_HCHK || phase_r == PH_BODY || phase_r == PH_BCHK))
    else $error("result produced outside header check, body or body check");

endmodule

// ===== rtl/serial_message_deframer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_message_deframer_core
// Recovers addressed frames from a received byte stream and reports body
// bytes, frame completion, header check errors and body check errors.
// ----------------------------------------------------------------------------
// One received byte is taken per clock while in_ch.ready is high. Each byte
// goes through the frame state machine in the cycle it is accepted and its
// result, if any, is stored in out_r. in_ch.ready is high whenever the
// output register is empty or its transaction completes in the same cycle,
// so with out_ch.ready held high the block sustains one byte per cycle.
// node_id is written through cfg_wr_en/cfg_wr_data and compared against the
// destination byte of each frame.
module serial_message_deframer_core (
  input  logic             clk,
  input  logic             rst_n,
  smd_in_if.sink           in_ch,
  smd_out_if.source        out_ch,
  input  logic             cfg_wr_en,
  input  logic [7:0]       cfg_wr_data
);
  import smd_pkg::*;

  logic        in_fire;
  logic [7:0]  node_id_r;
  logic        out_valid_r, out_valid_nxt;
  smd_result_t step_res;
  smd_result_t out_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  smd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_fire (in_fire),
    .rx_byte   (in_ch.rx_byte),
    .node_id   (node_id_r),
    .res       (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_id_r <= 8'd0;
    end else if (cfg_wr_en) begin
      node_id_r <= cfg_wr_data;
    end
  end

  always_comb begin
    if (in_fire) begin
      out_valid_nxt = step_res.valid;
    end else begin
      out_valid_nxt = out_valid_r && !out_ch.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && step_res.valid) begin
      out_r <= step_res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = out_r.kind;
  assign out_ch.src_addr    = out_r.src_addr;
  assign out_ch.reg_num     = out_r.reg_num;
  assign out_ch.flag_bits   = out_r.flag_bits;
  assign out_ch.body_length = out_r.body_length;
  assign out_ch.data_byte   = out_r.data_byte;
  assign out_ch.byte_index  = out_r.byte_index;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !in_fire)
    else $error("input transaction accepted while a stalled result is pending");

  a_non_body_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.kind != KIND_BODY) |->
      (out_r.data_byte == 8'd0 && out_r.byte_index == 8'd0))
    else $error("frame status result carries body byte fields");

  a_reset_clears_output: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("output valid after reset");

  a_result_needs_input: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r && !in_fire) |=> !out_valid_r)
    else $error("result appeared without an accepted input transaction");

endmodule
